// ===== rtl/core/cdq_pkg.sv =====
// Shared types and constants for the circular deque.
package cdq_pkg;

    localparam int DEPTH  = 16;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CAP_W  = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;
    localparam int FUNC_W = 3;
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    localparam logic [CAP_W-1:0]  CAP_RESET     = CAP_W'(DEPTH);
    localparam logic [APB_AW-1:0] ADDR_CAPACITY = APB_AW'(0);

    typedef enum logic [FUNC_W-1:0] {
        FN_INS_FRONT = 3'd0,
        FN_INS_REAR  = 3'd1,
        FN_DEL_FRONT = 3'd2,
        FN_DEL_REAR  = 3'd3,
        FN_STATUS    = 3'd4
    } t_func;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_READ,
        S_LOAD
    } t_state;

    typedef struct packed {
        logic latch;
        logic exec;
        logic load;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_stat;

endpackage

// ===== rtl/core/cdq_if.sv =====
// Handshake interfaces for the deque command and result channels.
interface cdq_in_if import cdq_pkg::*;;
    logic                      valid;
    logic                      ready;
    logic [FUNC_W-1:0]         func;
    logic signed [DATA_W-1:0]  value;

    modport source (output valid, output func, output value, input ready);
    modport sink   (input valid, input func, input value, output ready);
endinterface

interface cdq_out_if import cdq_pkg::*;;
    logic                      valid;
    logic                      ready;
    logic                      ok;
    logic signed [DATA_W-1:0]  front_value;
    logic signed [DATA_W-1:0]  rear_value;
    logic                      is_empty;
    logic                      is_full;

    modport source (output valid, output ok, output front_value, output rear_value,
                    output is_empty, output is_full, input ready);
    modport sink   (input valid, input ok, input front_value, input rear_value,
                    input is_empty, input is_full, output ready);
endinterface

// ===== rtl/core/circular_deque_top.sv =====
// Top level of the circular deque: channels, register port and the two halves.
//
// Double-ended queue in a 16-entry ring whose usable size is the capacity
// register at byte address 0 (reset 16; writing it also empties the deque).
// Each command (insert front/rear, delete front/rear, status) yields one
// result with ok, front and rear values (-1 when empty) and empty/full flags
// as they stand after the operation. The controller handles one command at a
// time and takes each through four steps: accept, index update with ring write,
// registered ring read, and result load. A new command is accepted only once
// the previous one has been loaded into the result register; the ring's
// registered read is why the read step is needed. A finished result sits in
// an output register, so the next command is accepted while it waits to be
// taken; a command only stalls in its load step while the previous result
// is still waiting. The deque is empty after reset with no clearing pass.
module circular_deque_top import cdq_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    cdq_in_if.sink            i_in,
    cdq_out_if.source         o_out,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    t_dp_cmd          cmd;
    t_dp_stat         stat;
    logic             cfg_wr;
    logic [CAP_W-1:0] cap;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr == ADDR_CAPACITY);

    always_comb begin
        prdata = '0;
        if (paddr == ADDR_CAPACITY) begin
            prdata = APB_DW'(cap);
        end
    end

    cdq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    cdq_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_cfg_wr      (cfg_wr),
        .i_cfg_cap     (pwdata[CAP_W-1:0]),
        .o_cap         (cap),
        .i_func        (i_in.func),
        .i_value       (i_in.value),
        .o_valid       (o_out.valid),
        .i_ready       (o_out.ready),
        .o_ok          (o_out.ok),
        .o_front_value (o_out.front_value),
        .o_rear_value  (o_out.rear_value),
        .o_is_empty    (o_out.is_empty),
        .o_is_full     (o_out.is_full)
    );

endmodule

// ===== rtl/core/cdq_ctrl.sv =====
// Controller state machine that sequences one deque operation at a time.
module cdq_ctrl import cdq_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_READ;
            end
            S_READ: begin
                n_state = S_LOAD;
            end
            S_LOAD: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            S_IDLE: begin
                o_in_ready  = 1'b1;
                o_cmd.latch = i_in_valid;
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
            end
            S_READ: begin
                o_cmd = '0;
            end
            S_LOAD: begin
                o_cmd.load = i_stat.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

// ===== rtl/core/cdq_dp.sv =====
// Datapath: ring storage, front and rear indices, capacity and the result register.
module cdq_dp import cdq_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_dp_cmd                  i_cmd,
    output t_dp_stat                 o_stat,
    input  logic                     i_cfg_wr,
    input  logic [CAP_W-1:0]         i_cfg_cap,
    output logic [CAP_W-1:0]         o_cap,
    input  logic [FUNC_W-1:0]        i_func,
    input  logic signed [DATA_W-1:0] i_value,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic                     o_ok,
    output logic signed [DATA_W-1:0] o_front_value,
    output logic signed [DATA_W-1:0] o_rear_value,
    output logic                     o_is_empty,
    output logic                     o_is_full
);

    logic [DATA_W-1:0] r_ring [DEPTH];

    logic [CAP_W-1:0]  r_cap;
    t_func             r_func;
    logic [DATA_W-1:0] r_value;
    logic [IDX_W-1:0]  r_front;
    logic [IDX_W-1:0]  r_rear;
    logic              r_empty;
    logic              r_ok;
    logic [DATA_W-1:0] r_rd_front;
    logic [DATA_W-1:0] r_rd_rear;

    logic              r_out_valid;
    logic              r_out_ok;
    logic [DATA_W-1:0] r_out_front;
    logic [DATA_W-1:0] r_out_rear;
    logic              r_out_empty;
    logic              r_out_full;

    logic [CAP_W-1:0]  eff_cap;
    logic [IDX_W-1:0]  front_next;
    logic [IDX_W-1:0]  front_prev;
    logic [IDX_W-1:0]  rear_next;
    logic [IDX_W-1:0]  rear_prev;
    logic              full_now;

    logic [IDX_W-1:0]  n_front;
    logic [IDX_W-1:0]  n_rear;
    logic              n_empty;
    logic              n_ok;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;

    // A capacity of zero behaves as one; anything above the ring size saturates.
    always_comb begin
        eff_cap = r_cap;
        if (r_cap == '0) begin
            eff_cap = CAP_W'(1);
        end else if (r_cap > CAP_W'(DEPTH)) begin
            eff_cap = CAP_W'(DEPTH);
        end
    end

    always_comb begin
        front_next = ((CAP_W'(r_front) + CAP_W'(1)) >= eff_cap) ? '0 : r_front + IDX_W'(1);
        rear_next  = ((CAP_W'(r_rear) + CAP_W'(1)) >= eff_cap) ? '0 : r_rear + IDX_W'(1);
        front_prev = (r_front == '0 || CAP_W'(r_front) >= eff_cap)
                     ? IDX_W'(eff_cap - CAP_W'(1)) : r_front - IDX_W'(1);
        rear_prev  = (r_rear == '0 || CAP_W'(r_rear) >= eff_cap)
                     ? IDX_W'(eff_cap - CAP_W'(1)) : r_rear - IDX_W'(1);
        full_now   = !r_empty && (rear_next == r_front);
    end

    always_comb begin
        n_front = r_front;
        n_rear  = r_rear;
        n_empty = r_empty;
        n_ok    = 1'b1;
        wr_en   = 1'b0;
        wr_addr = '0;
        case (r_func)
            FN_INS_FRONT, FN_INS_REAR: begin
                if (r_empty) begin
                    n_front = '0;
                    n_rear  = '0;
                    n_empty = 1'b0;
                    wr_en   = 1'b1;
                    wr_addr = '0;
                end else if (full_now) begin
                    n_ok = 1'b0;
                end else if (r_func == FN_INS_FRONT) begin
                    n_front = front_prev;
                    wr_en   = 1'b1;
                    wr_addr = front_prev;
                end else begin
                    n_rear  = rear_next;
                    wr_en   = 1'b1;
                    wr_addr = rear_next;
                end
            end
            FN_DEL_FRONT, FN_DEL_REAR: begin
                if (r_empty) begin
                    n_ok = 1'b0;
                end else if (r_front == r_rear) begin
                    // Removing the last element returns both indices home.
                    n_front = '0;
                    n_rear  = '0;
                    n_empty = 1'b1;
                end else if (r_func == FN_DEL_FRONT) begin
                    n_front = front_next;
                end else begin
                    n_rear = rear_prev;
                end
            end
            default: begin
                n_ok = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap   <= CAP_RESET;
            r_front <= '0;
            r_rear  <= '0;
            r_empty <= 1'b1;
        end else if (i_cfg_wr) begin
            r_cap   <= i_cfg_cap;
            r_front <= '0;
            r_rear  <= '0;
            r_empty <= 1'b1;
        end else if (i_cmd.exec) begin
            r_front <= n_front;
            r_rear  <= n_rear;
            r_empty <= n_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_func  <= t_func'(i_func);
            r_value <= i_value;
        end
        if (i_cmd.exec) begin
            r_ok <= n_ok;
        end
    end

    // Ring storage: one write port, two registered read ports.
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && wr_en) begin
            r_ring[wr_addr] <= r_value;
        end
        r_rd_front <= r_ring[r_front];
        r_rd_rear  <= r_ring[r_rear];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_out_ok    <= r_ok;
            r_out_front <= r_empty ? '1 : r_rd_front;
            r_out_rear  <= r_empty ? '1 : r_rd_rear;
            r_out_empty <= r_empty;
            r_out_full  <= full_now;
        end
    end

    assign o_stat.out_free = !r_out_valid || i_ready;
    assign o_cap           = r_cap;
    assign o_valid         = r_out_valid;
    assign o_ok            = r_out_ok;
    assign o_front_value   = r_out_front;
    assign o_rear_value    = r_out_rear;
    assign o_is_empty      = r_out_empty;
    assign o_is_full       = r_out_full;

endmodule

// ===== bench/testbench.sv =====
// Self-checking testbench for the circular deque: directed and random commands checked per result.
module testbench;
    import cdq_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 9;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 80;

    // Codes outside the defined set behave as a status read.
    localparam logic [FUNC_W-1:0] FN_SPARE_5 = FUNC_W'(5);
    localparam logic [FUNC_W-1:0] FN_SPARE_6 = FUNC_W'(6);
    localparam logic [FUNC_W-1:0] FN_SPARE_7 = FUNC_W'(7);
    localparam logic [APB_AW-1:0] ADDR_UNMAPPED = APB_AW'(4);
    localparam logic [DATA_W-1:0] EMPTY_MARK = '1;

    typedef struct {
        logic              ok;
        logic [DATA_W-1:0] front_v;
        logic [DATA_W-1:0] rear_v;
        logic              empty;
        logic              full;
    } t_deque_view;

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    cdq_in_if  cmd_ch ();
    cdq_out_if rsp_ch ();

    circular_deque_top i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (cmd_ch),
        .o_out   (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Behavioral copy of the deque.
    logic [DATA_W-1:0] ring_copy [DEPTH];
    int                front_pos;
    int                rear_pos;
    bit                deque_empty;
    logic [CAP_W-1:0]  capacity_reg;

    t_deque_view expected_views[$];
    int          error_count;
    int          cycle_count;
    bit          idling_on;
    bit          hold_off_req;

    initial begin
        i_clk = 1'b0;
    end

    always #CLK_HALF i_clk = ~i_clk;

    function automatic int usable_capacity();
        int c;
        c = capacity_reg;
        if (c == 0) c = 1;
        if (c > DEPTH) c = DEPTH;
        return c;
    endfunction

    function automatic int ring_next(int i, int c);
        return (i + 1 >= c) ? 0 : i + 1;
    endfunction

    function automatic int ring_prev(int i, int c);
        return (i == 0 || i >= c) ? c - 1 : i - 1;
    endfunction

    function automatic bit deque_full(int c);
        return !deque_empty && ring_next(rear_pos, c) == front_pos;
    endfunction

    function automatic void clear_deque();
        front_pos   = 0;
        rear_pos    = 0;
        deque_empty = 1'b1;
    endfunction

    // Applies one command to the behavioral deque and queues the view it leaves.
    function automatic void apply_deque_op(logic [FUNC_W-1:0] fn, logic [DATA_W-1:0] val);
        int          c;
        t_deque_view v;
        c = usable_capacity();
        v.ok = 1'b1;
        case (fn)
            FN_INS_FRONT, FN_INS_REAR: begin
                if (deque_empty) begin
                    front_pos    = 0;
                    rear_pos     = 0;
                    ring_copy[0] = val;
                    deque_empty  = 1'b0;
                end else if (deque_full(c)) begin
                    v.ok = 1'b0;
                end else if (fn == FN_INS_FRONT) begin
                    front_pos = ring_prev(front_pos, c);
                    ring_copy[front_pos] = val;
                end else begin
                    rear_pos = ring_next(rear_pos, c);
                    ring_copy[rear_pos] = val;
                end
            end
            FN_DEL_FRONT, FN_DEL_REAR: begin
                if (deque_empty) begin
                    v.ok = 1'b0;
                end else if (front_pos == rear_pos) begin
                    clear_deque();
                end else if (fn == FN_DEL_FRONT) begin
                    front_pos = ring_next(front_pos, c);
                end else begin
                    rear_pos = ring_prev(rear_pos, c);
                end
            end
            default: ;
        endcase
        v.front_v = deque_empty ? EMPTY_MARK : ring_copy[front_pos];
        v.rear_v  = deque_empty ? EMPTY_MARK : ring_copy[rear_pos];
        v.empty   = deque_empty;
        v.full    = deque_full(c);
        expected_views.push_back(v);
    endfunction

    // Offers one command and returns at the edge where it transfers.
    // The valid stays high so that a following command can go back to back.
    task automatic send_command(input logic [FUNC_W-1:0] fn, input logic [DATA_W-1:0] val);
        if (idling_on && $urandom_range(0, 4) == 0) begin
            cmd_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.func  <= fn;
        cmd_ch.value <= val;
        do @(posedge i_clk); while (!cmd_ch.ready);
        apply_deque_op(fn, val);
    endtask

    task automatic wait_results_drained();
        cmd_ch.valid <= 1'b0;
        while (expected_views.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic reg_write(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_CAPACITY) begin
            capacity_reg = data[CAP_W-1:0];
            clear_deque();
        end
    endtask

    task automatic set_capacity(input logic [CAP_W-1:0] cap);
        logic [APB_DW-1:0] data;
        data = APB_DW'(cap);
        // Half the writes carry junk above the register field.
        if ($urandom_range(0, 1) == 1) data = ($urandom() & ~APB_DW'(32'h1F)) | data;
        wait_results_drained();
        reg_write(ADDR_CAPACITY, data);
    endtask

    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return '0;
            3: return '1;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [FUNC_W-1:0] pick_command(int insert_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < 8) return FUNC_W'($urandom_range(FN_STATUS, FN_SPARE_7));
        if (r < 8 + insert_pct) return $urandom_range(0, 1) ? FN_INS_REAR : FN_INS_FRONT;
        return $urandom_range(0, 1) ? FN_DEL_REAR : FN_DEL_FRONT;
    endfunction

    task automatic test_empty_refusals();
        send_command(FN_STATUS, pick_value());
        send_command(FN_DEL_FRONT, pick_value());
        send_command(FN_DEL_REAR, pick_value());
        send_command(FN_SPARE_5, pick_value());
        send_command(FN_SPARE_6, pick_value());
        send_command(FN_SPARE_7, pick_value());
    endtask

    task automatic test_extreme_values();
        send_command(FN_INS_REAR, 32'h7FFF_FFFF);
        send_command(FN_INS_FRONT, 32'h8000_0000);
        send_command(FN_DEL_REAR, '0);
        send_command(FN_DEL_FRONT, '1);
    endtask

    // With two entries the front insert wraps below index zero.
    task automatic test_small_ring_wrap();
        set_capacity(CAP_W'(2));
        send_command(FN_INS_FRONT, '0);
        send_command(FN_INS_FRONT, '1);
        send_command(FN_INS_REAR, 32'h1234_5678);
        send_command(FN_DEL_REAR, '0);
        send_command(FN_DEL_REAR, '0);
    endtask

    task automatic test_capacity_limits();
        set_capacity(CAP_W'(0));
        send_command(FN_INS_REAR, 32'h0000_0001);
        send_command(FN_INS_FRONT, 32'h0000_0002);
        send_command(FN_DEL_FRONT, '0);
        set_capacity('1);
        send_command(FN_INS_REAR, 32'hA5A5_5A5A);
        send_command(FN_STATUS, '0);
    endtask

    // A write to an address past the register list must leave the full deque alone.
    task automatic test_unmapped_write();
        set_capacity(CAP_W'(3));
        send_command(FN_INS_REAR, 32'h0000_0011);
        send_command(FN_INS_REAR, 32'h0000_0022);
        send_command(FN_INS_FRONT, 32'h0000_0033);
        wait_results_drained();
        reg_write(ADDR_UNMAPPED, APB_DW'(1));
        send_command(FN_INS_REAR, 32'h0000_0044);
        send_command(FN_STATUS, '0);
    endtask

    // The insert share swings between phases so the deque walks from empty to full.
    task automatic test_random_walk(input logic [CAP_W-1:0] cap, input int n_items);
        int insert_pct;
        set_capacity(cap);
        insert_pct = 50;
        for (int k = 0; k < n_items; k++) begin
            if (k % 24 == 0) begin
                case ($urandom_range(0, 2))
                    0: insert_pct = 15;
                    1: insert_pct = 46;
                    default: insert_pct = 80;
                endcase
            end
            send_command(pick_command(insert_pct), pick_value());
        end
    endtask

    task automatic test_backpressure();
        wait_results_drained();
        hold_off_req = 1'b1;
        for (int k = 0; k < 30; k++) send_command(pick_command(50), pick_value());
        wait_results_drained();
    endtask

    task automatic test_steady_stream();
        set_capacity(CAP_W'(DEPTH));
        idling_on = 1'b0;
        for (int k = 0; k < 150; k++) send_command(pick_command(48), pick_value());
    endtask

    // Result side: random stalls, plus one long hold-off on request.
    initial begin
        int stall_left;
        stall_left   = 0;
        rsp_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_left > 0) begin
                rsp_ch.ready <= 1'b0;
                stall_left--;
            end else if (hold_off_req) begin
                hold_off_req = 1'b0;
                stall_left   = HOLD_CYCLES - 1;
                rsp_ch.ready <= 1'b0;
            end else if (idling_on && $urandom_range(0, 5) == 0) begin
                stall_left   = $urandom_range(0, 6);
                rsp_ch.ready <= 1'b0;
            end else begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    // Compares every result transfer against the oldest expected view.
    initial begin
        t_deque_view exp_v;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
                if (expected_views.size() == 0) begin
                    error_count++;
                    $display({"%0t: result transfer with nothing expected, got ok=%b ",
                              "front=%h rear=%h empty=%b full=%b"}, $time,
                             rsp_ch.ok, rsp_ch.front_value, rsp_ch.rear_value,
                             rsp_ch.is_empty, rsp_ch.is_full);
                end else begin
                    exp_v = expected_views.pop_front();
                    if (rsp_ch.ok !== exp_v.ok || rsp_ch.front_value !== exp_v.front_v ||
                        rsp_ch.rear_value !== exp_v.rear_v ||
                        rsp_ch.is_empty !== exp_v.empty || rsp_ch.is_full !== exp_v.full) begin
                        error_count++;
                        $display({"%0t: mismatch expected ok=%b front=%h rear=%h ",
                                  "empty=%b full=%b, got ok=%b front=%h rear=%h ",
                                  "empty=%b full=%b"}, $time,
                                 exp_v.ok, exp_v.front_v, exp_v.rear_v, exp_v.empty,
                                 exp_v.full, rsp_ch.ok, rsp_ch.front_value,
                                 rsp_ch.rear_value, rsp_ch.is_empty, rsp_ch.is_full);
                    end
                end
            end
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("** circular_deque_top: FAILED **");
        $finish;
    end

    initial begin
        i_rst_n      = 1'b0;
        cmd_ch.valid = 1'b0;
        cmd_ch.func  = FN_STATUS;
        cmd_ch.value = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        error_count  = 0;
        idling_on    = 1'b1;
        hold_off_req = 1'b0;
        capacity_reg = CAP_RESET;
        clear_deque();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_refusals();
        test_extreme_values();
        test_small_ring_wrap();
        test_capacity_limits();
        test_unmapped_write();
        test_random_walk(CAP_W'(1), 90);
        test_random_walk(CAP_W'(2), 100);
        test_random_walk(CAP_W'(3), 100);
        test_random_walk(CAP_W'(4), 110);
        test_random_walk(CAP_W'(5), 110);
        test_random_walk(CAP_W'(8), 120);
        test_backpressure();
        test_random_walk(CAP_W'(15), 130);
        test_random_walk(CAP_W'(DEPTH), 140);
        test_random_walk(CAP_W'(17), 120);
        test_random_walk('1, 110);
        test_random_walk(CAP_W'(0), 80);
        test_random_walk(CAP_W'($urandom_range(1, DEPTH)), 110);
        test_random_walk(CAP_W'($urandom_range(0, 31)), 110);
        test_steady_stream();
        wait_results_drained();

        if (error_count == 0) begin
            $display("** circular_deque_top: PASSED **");
        end else begin
            $display("** circular_deque_top: FAILED **");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/cdq_pkg.sv
rtl/core/cdq_if.sv
rtl/core/cdq_ctrl.sv
rtl/core/cdq_dp.sv
rtl/core/circular_deque_top.sv
bench/testbench.sv
